@@ design/ccc_pkg.sv @@
package ccc_pkg;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MS_IN_W  = 10;
    localparam int MS_W     = 11;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [YEAR_W-1:0]   RESET_YEAR      = 7'd19;
    localparam logic [MONTH_W-1:0]  RESET_MONTH     = 4'd5;
    localparam logic [DAY_W-1:0]    RESET_DAY       = 5'd8;
    localparam logic [HOUR_W-1:0]   RESET_HOUR      = 5'd12;
    localparam logic [YEAR_W-1:0]   RESET_MIN_YEAR  = 7'd19;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } ccc_time_t;

    // Length of a non-leap month; codes outside 1..12 count as 31 days.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

@@ design/ccc_channels.sv @@
interface ccc_request_if;
    import ccc_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [MS_IN_W-1:0]  ms_elapsed;
    logic [YEAR_W-1:0]   load_year;
    logic [MONTH_W-1:0]  load_month;
    logic [DAY_W-1:0]    load_day;
    logic [HOUR_W-1:0]   load_hour;
    logic [MINUTE_W-1:0] load_minute;
    logic [SECOND_W-1:0] load_second;

    modport source (output valid, command, ms_elapsed, load_year, load_month, load_day,
                    load_hour, load_minute, load_second, input ready);
    modport sink   (input valid, command, ms_elapsed, load_year, load_month, load_day,
                    load_hour, load_minute, load_second, output ready);
endinterface

interface ccc_result_if;
    import ccc_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;
    logic [MS_W-1:0]     millisecond_out;
    logic                load_rejected;

    modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
                    second_out, millisecond_out, load_rejected, input ready);
    modport sink   (input valid, year_out, month_out, day_out, hour_out, minute_out,
                    second_out, millisecond_out, load_rejected, output ready);
endinterface

interface ccc_cfg_if;
    import ccc_pkg::*;

    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/ccc_advance.sv @@
module ccc_advance (
    input  ccc_pkg::ccc_time_t cur,
    output ccc_pkg::ccc_time_t nxt
);
    import ccc_pkg::*;

    logic [SECOND_W-1:0] sec_inc;
    logic [MINUTE_W-1:0] min_inc;
    logic [HOUR_W-1:0]   hour_inc;
    logic [DAY_W-1:0]    day_inc;
    logic [MONTH_W-1:0]  month_inc;
    logic [YEAR_W-1:0]   year_inc;
    logic                leap_feb;

    assign sec_inc   = cur.second + 6'd1;
    assign min_inc   = cur.minute + 6'd1;
    assign hour_inc  = cur.hour + 5'd1;
    assign day_inc   = cur.day + 5'd1;
    assign month_inc = cur.month + 4'd1;
    assign year_inc  = cur.year + 7'd1;
    assign leap_feb  = (cur.month == 4'd2) && (cur.year[1:0] == 2'd0);

    // Each field wraps at its limit, and a field that was loaded past its
    // limit wraps on its first increment as well.
    always_comb
    begin
        nxt = cur;
        nxt.second = sec_inc;
        if (sec_inc > 6'd59 || sec_inc == 6'd0)
        begin
            nxt.second = '0;
            nxt.minute = min_inc;
            if (min_inc > 6'd59 || min_inc == 6'd0)
            begin
                nxt.minute = '0;
                nxt.hour   = hour_inc;
                if (hour_inc > 5'd23 || hour_inc == 5'd0)
                begin
                    nxt.hour = '0;
                    nxt.day  = day_inc;
                    if (leap_feb)
                    begin
                        if (day_inc > 5'd29 || day_inc == 5'd0)
                        begin
                            nxt.day   = 5'd1;
                            nxt.month = 4'd3;
                        end
                    end
                    else if (day_inc > month_length(cur.month) || day_inc == 5'd0)
                    begin
                        nxt.day   = 5'd1;
                        nxt.month = month_inc;
                        if (month_inc > 4'd12 || month_inc == 4'd0)
                        begin
                            nxt.month = 4'd1;
                            nxt.year  = (year_inc > 7'd99) ? 7'd0 : year_inc;
                        end
                    end
                end
            end
        end
    end

endmodule

@@ design/calendar_clock_counter.sv @@
// Calendar clock with a millisecond accumulator. A tick item adds ms_elapsed
// to the accumulator; a load item sets date and time when the year is at
// least min_year_reg, the month is 1 to 12 and the day is nonzero, and
// otherwise reports load_rejected. On every item the clock advances by at
// most one second, taken when the accumulator is above 999. Every item gives
// exactly one result, which appears in the output register in the cycle after
// the item is accepted. One item is accepted per cycle: the whole carry chain
// from accumulator to year is evaluated between the state registers and the
// output register, and a new item is taken whenever the output register is
// empty or its result is being taken in the same cycle. Configuration writes
// are always ready and take effect for the next item.
module calendar_clock_counter (
    input  logic        clk,
    input  logic        rst_n,
    ccc_request_if.sink request,
    ccc_result_if.source result,
    ccc_cfg_if.sink     cfg
);
    import ccc_pkg::*;

    localparam logic [MS_W:0] MS_LIMIT = 12'd999;
    localparam logic [MS_W:0] MS_STEP  = 12'd1000;
    localparam logic [MS_W:0] MS_SAT   = 12'd2047;

    ccc_time_t           time_reg;
    ccc_time_t           time_next;
    ccc_time_t           loaded;
    ccc_time_t           advanced;
    logic [MS_W-1:0]     ms_accum_reg;
    logic [MS_W-1:0]     ms_next;
    logic [YEAR_W-1:0]   min_year_reg;
    logic                out_valid_reg;
    logic                rejected_next;
    logic                load_ok;
    logic [MS_W:0]       sum;
    logic [MS_W:0]       sum_sub;
    logic                accept;

    logic [YEAR_W-1:0]   year_out_reg;
    logic [MONTH_W-1:0]  month_out_reg;
    logic [DAY_W-1:0]    day_out_reg;
    logic [HOUR_W-1:0]   hour_out_reg;
    logic [MINUTE_W-1:0] minute_out_reg;
    logic [SECOND_W-1:0] second_out_reg;
    logic [MS_W-1:0]     ms_out_reg;
    logic                rejected_out_reg;

    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign cfg.ready     = 1'b1;

    assign load_ok = (request.load_year >= min_year_reg) &&
                     (request.load_month >= 4'd1) && (request.load_month <= 4'd12) &&
                     (request.load_day != 5'd0);

    always_comb
    begin
        loaded        = time_reg;
        rejected_next = 1'b0;
        sum           = {1'b0, ms_accum_reg};
        if (request.command == CMD_TICK)
        begin
            sum = {1'b0, ms_accum_reg} + {2'b00, request.ms_elapsed};
        end
        else if (load_ok)
        begin
            loaded.year   = request.load_year;
            loaded.month  = request.load_month;
            loaded.day    = request.load_day;
            loaded.hour   = request.load_hour;
            loaded.minute = request.load_minute;
            loaded.second = request.load_second;
        end
        else
        begin
            rejected_next = 1'b1;
        end
    end

    ccc_advance u_advance (
        .cur (loaded),
        .nxt (advanced)
    );

    always_comb
    begin
        sum_sub   = sum;
        time_next = loaded;
        if (sum > MS_LIMIT)
        begin
            sum_sub   = sum - MS_STEP;
            time_next = advanced;
        end
        ms_next = (sum_sub > MS_SAT) ? MS_SAT[MS_W-1:0] : sum_sub[MS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.year   <= RESET_YEAR;
            time_reg.month  <= RESET_MONTH;
            time_reg.day    <= RESET_DAY;
            time_reg.hour   <= RESET_HOUR;
            time_reg.minute <= '0;
            time_reg.second <= '0;
            ms_accum_reg    <= '0;
            min_year_reg    <= RESET_MIN_YEAR;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                min_year_reg <= cfg.data;
            end
            if (accept)
            begin
                time_reg     <= time_next;
                ms_accum_reg <= ms_next;
            end
            if (request.ready)
            begin
                out_valid_reg <= request.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            year_out_reg     <= time_next.year;
            month_out_reg    <= time_next.month;
            day_out_reg      <= time_next.day;
            hour_out_reg     <= time_next.hour;
            minute_out_reg   <= time_next.minute;
            second_out_reg   <= time_next.second;
            ms_out_reg       <= ms_next;
            rejected_out_reg <= rejected_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.year_out        = year_out_reg;
    assign result.month_out       = month_out_reg;
    assign result.day_out         = day_out_reg;
    assign result.hour_out        = hour_out_reg;
    assign result.minute_out      = minute_out_reg;
    assign result.second_out      = second_out_reg;
    assign result.millisecond_out = ms_out_reg;
    assign result.load_rejected   = rejected_out_reg;

endmodule

@@ verif/tb_calendar_clock_counter.sv @@
module tb_calendar_clock_counter;
    import ccc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct {
        logic                command;
        logic [MS_IN_W-1:0]  ms_elapsed;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } clock_request_t;

    typedef struct {
        ccc_time_t       stamp;
        logic [MS_W-1:0] millis;
        logic            rejected;
    } clock_reading_t;

    class calendar_scoreboard;
        ccc_time_t         now;
        logic [MS_W-1:0]   millis;
        logic [YEAR_W-1:0] min_year;
        clock_reading_t    pending_readings[$];
        int unsigned       errors, ticks, loads, rejects, day_rolls, year_wraps;

        function new();
            now.year   = RESET_YEAR;
            now.month  = RESET_MONTH;
            now.day    = RESET_DAY;
            now.hour   = RESET_HOUR;
            now.minute = '0;
            now.second = '0;
            millis     = '0;
            min_year   = RESET_MIN_YEAR;
        endfunction

        function void set_min_year(logic [YEAR_W-1:0] y);
            min_year = y;
        endfunction

        function int unsigned depth();
            return pending_readings.size();
        endfunction

        // Month codes outside 1 to 12 never come from a load, but count as 31 days.
        function void roll_day();
            int unsigned limit;
            now.day = now.day + 1'b1;
            day_rolls++;
            if (now.month == 2)
                limit = (now.year[1:0] == 2'b00) ? 29 : 28;
            else if (now.month == 4 || now.month == 6 || now.month == 9 || now.month == 11)
                limit = 30;
            else
                limit = 31;
            if (now.day > limit || now.day == 0) begin
                now.day   = 1;
                now.month = now.month + 1'b1;
                if (now.month > 12 || now.month == 0) begin
                    now.month = 1;
                    now.year  = now.year + 1'b1;
                    if (now.year > 99)
                        now.year = 0;
                    if (now.year == 0)
                        year_wraps++;
                end
            end
        endfunction

        // Loaded hour, minute and second are unchecked, so anything past its limit
        // rolls to zero here as well as the normal wrap.
        function void tick_second();
            now.second = now.second + 1'b1;
            if (now.second > 59 || now.second == 0) begin
                now.second = 0;
                now.minute = now.minute + 1'b1;
                if (now.minute > 59 || now.minute == 0) begin
                    now.minute = 0;
                    now.hour   = now.hour + 1'b1;
                    if (now.hour > 23 || now.hour == 0) begin
                        now.hour = 0;
                        roll_day();
                    end
                end
            end
        endfunction

        function void note_request(clock_request_t r);
            int unsigned    total;
            clock_reading_t want;
            want.rejected = 1'b0;
            if (r.command == CMD_TICK) begin
                ticks++;
                total = 32'(millis) + 32'(r.ms_elapsed);
            end
            else begin
                loads++;
                total = 32'(millis);
                if (r.year >= min_year && r.month >= 1 && r.month <= 12 && r.day >= 1) begin
                    now.year   = r.year;
                    now.month  = r.month;
                    now.day    = r.day;
                    now.hour   = r.hour;
                    now.minute = r.minute;
                    now.second = r.second;
                end
                else begin
                    want.rejected = 1'b1;
                    rejects++;
                end
            end
            // At most one second per item; the accumulator saturates if it runs away.
            if (total > 999) begin
                total = total - 1000;
                tick_second();
            end
            if (total > 2047)
                total = 2047;
            millis      = MS_W'(total);
            want.stamp  = now;
            want.millis = millis;
            pending_readings.push_back(want);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_reading(clock_reading_t got);
            clock_reading_t want;
            if (pending_readings.size() == 0) begin
                $error("result arrived with no item outstanding");
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            compare("year_out", 16'(want.stamp.year), 16'(got.stamp.year));
            compare("month_out", 16'(want.stamp.month), 16'(got.stamp.month));
            compare("day_out", 16'(want.stamp.day), 16'(got.stamp.day));
            compare("hour_out", 16'(want.stamp.hour), 16'(got.stamp.hour));
            compare("minute_out", 16'(want.stamp.minute), 16'(got.stamp.minute));
            compare("second_out", 16'(want.stamp.second), 16'(got.stamp.second));
            compare("millisecond_out", 16'(want.millis), 16'(got.millis));
            compare("load_rejected", 16'(want.rejected), 16'(got.rejected));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ccc_request_if request_ch ();
    ccc_result_if  result_ch ();
    ccc_cfg_if     cfg_ch ();

    calendar_clock_counter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    calendar_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned sender_mode = 0;
    int unsigned cfg_writes  = 0;
    int unsigned cycle_count = 0;
    logic [11:0] stall_phase = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver walks through four stall styles, chosen by stall_phase[9:8].
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: result_ch.ready <= 1'b1;
            2'd1: result_ch.ready <= ($urandom_range(0, 9) < 7);
            2'd2: result_ch.ready <= (stall_phase[1:0] == 2'b00);
            default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin : monitor
        clock_reading_t seen;
        clock_request_t taken;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                seen.stamp.year   = result_ch.year_out;
                seen.stamp.month  = result_ch.month_out;
                seen.stamp.day    = result_ch.day_out;
                seen.stamp.hour   = result_ch.hour_out;
                seen.stamp.minute = result_ch.minute_out;
                seen.stamp.second = result_ch.second_out;
                seen.millis       = result_ch.millisecond_out;
                seen.rejected     = result_ch.load_rejected;
                sb.check_reading(seen);
            end
            if (request_ch.valid && request_ch.ready) begin
                taken.command    = request_ch.command;
                taken.ms_elapsed = request_ch.ms_elapsed;
                taken.year       = request_ch.load_year;
                taken.month      = request_ch.load_month;
                taken.day        = request_ch.load_day;
                taken.hour       = request_ch.load_hour;
                taken.minute     = request_ch.load_minute;
                taken.second     = request_ch.load_second;
                sb.note_request(taken);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_min_year(cfg_ch.data);
        end
    end

    function automatic clock_request_t random_request();
        clock_request_t r;
        r.command    = 1'($urandom_range(0, 1));
        r.ms_elapsed = MS_IN_W'($urandom_range(0, 1023));
        r.year       = YEAR_W'($urandom_range(0, 127));
        r.month      = MONTH_W'($urandom_range(0, 15));
        r.day        = DAY_W'($urandom_range(0, 31));
        r.hour       = HOUR_W'($urandom_range(0, 31));
        r.minute     = MINUTE_W'($urandom_range(0, 63));
        r.second     = SECOND_W'($urandom_range(0, 63));
        return r;
    endfunction

    // Valid stays high across a burst; a gap is only opened before a new burst.
    task automatic send_item(clock_request_t r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_mode == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                request_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        request_ch.valid       <= 1'b1;
        request_ch.command     <= r.command;
        request_ch.ms_elapsed  <= r.ms_elapsed;
        request_ch.load_year   <= r.year;
        request_ch.load_month  <= r.month;
        request_ch.load_day    <= r.day;
        request_ch.load_hour   <= r.hour;
        request_ch.load_minute <= r.minute;
        request_ch.load_second <= r.second;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick(int unsigned ms);
        clock_request_t r;
        r            = random_request();
        r.command    = CMD_TICK;
        r.ms_elapsed = MS_IN_W'(ms);
        send_item(r);
    endtask

    task automatic send_load(int unsigned y, int unsigned mo, int unsigned d,
                             int unsigned h, int unsigned mi, int unsigned s);
        clock_request_t r;
        r         = random_request();
        r.command = CMD_LOAD;
        r.year    = YEAR_W'(y);
        r.month   = MONTH_W'(mo);
        r.day     = DAY_W'(d);
        r.hour    = HOUR_W'(h);
        r.minute  = MINUTE_W'(mi);
        r.second  = SECOND_W'(s);
        send_item(r);
    endtask

    task automatic settle();
        request_ch.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (sb.depth() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_min_year(int unsigned y);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= YEAR_W'(y);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    // Load a time just short of a rollover, then push whole seconds through it.
    task automatic chase_rollover();
        int unsigned lo, y, mo, d, h, mi, s, n;
        lo = 32'(sb.min_year);
        y  = ($urandom_range(0, 9) == 0) ? $urandom_range(lo, 127) : $urandom_range(lo, 99);
        if ($urandom_range(0, 3) == 0)
            mo = 12;
        else if ($urandom_range(0, 3) == 0)
            mo = 2;
        else
            mo = $urandom_range(1, 12);
        d  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : $urandom_range(28, 31);
        h  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 23;
        mi = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : 59;
        s  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(56, 59);
        send_load(y, mo, d, h, mi, s);
        n = $urandom_range(2, 8);
        repeat (n)
            send_tick(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(950, 1023));
    endtask

    // Ticks of 1023 ms build up the accumulator, which may reach saturation; loads
    // land in between, then it is drained again.
    task automatic overflow_run();
        int unsigned n;
        n = $urandom_range(40, 70);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_load($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
            else
                send_tick(1023);
        end
        repeat ($urandom_range(2, 4))
            send_tick($urandom_range(0, 100));
    endtask

    initial
    begin
        int unsigned next_cfg_at, pick;
        request_ch.valid       <= 1'b0;
        request_ch.command     <= CMD_TICK;
        request_ch.ms_elapsed  <= '0;
        request_ch.load_year   <= '0;
        request_ch.load_month  <= '0;
        request_ch.load_day    <= '0;
        request_ch.load_hour   <= '0;
        request_ch.load_minute <= '0;
        request_ch.load_second <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.data            <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(0);
        send_tick(999);
        send_tick(1);
        send_tick(1023);
        send_load(18, 6, 15, 10, 20, 30);
        send_load(19, 0, 10, 1, 2, 3);
        send_load(19, 13, 10, 1, 2, 3);
        send_load(127, 15, 31, 31, 63, 63);
        send_load(19, 1, 0, 1, 2, 3);
        send_load(19, 12, 31, 23, 59, 59);
        send_tick(999);
        send_load(99, 12, 31, 23, 59, 59);
        send_tick(1000);
        send_load(20, 2, 29, 23, 59, 59);
        send_tick(1010);
        send_load(21, 2, 28, 23, 59, 59);
        send_tick(1010);
        send_load(22, 4, 31, 23, 59, 59);
        send_tick(1010);
        send_load(127, 12, 31, 23, 59, 59);
        send_tick(1010);
        send_load(30, 7, 4, 31, 63, 63);
        send_tick(1010);

        write_min_year(0);
        send_load(0, 1, 1, 0, 0, 0);
        write_min_year(99);
        send_load(98, 6, 1, 0, 0, 0);
        send_load(99, 6, 1, 0, 0, 0);

        next_cfg_at = items_sent + 300;
        while (items_sent < 1680) begin
            if (items_sent >= next_cfg_at) begin
                case ($urandom_range(0, 3))
                    0: write_min_year(0);
                    1: write_min_year(99);
                    2: write_min_year(32'(RESET_MIN_YEAR));
                    default: write_min_year($urandom_range(0, 99));
                endcase
                next_cfg_at = items_sent + $urandom_range(200, 400);
            end
            if ($urandom_range(0, 7) == 0)
                sender_mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 62)
                chase_rollover();
            else if (pick < 80)
                repeat ($urandom_range(1, 6))
                    send_item(random_request());
            else if (pick < 96)
                repeat ($urandom_range(1, 6))
                    send_tick($urandom_range(0, 1023));
            else
                overflow_run();
        end

        settle();
        $display("Ran %0d items: %0d ticks, %0d loads of which %0d were refused.",
                 items_sent, sb.ticks, sb.loads, sb.rejects);
        $display("Saw %0d day rollovers and %0d year wraps across %0d minimum-year settings.",
                 sb.day_rolls, sb.year_wraps, cfg_writes + 1);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
